/* hw/rtl/eso_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eso_pkg: joint extended state observer package
// Item types, microcode encoding and the observer program ROM.
// ----------------------------------------------------------------------------
package eso_pkg;

   localparam int STEP_W     = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int EST_W      = 48;
   localparam int ACC_W      = 51;
   localparam int PROD_W     = 96;
   localparam int DIGIT_W    = 16;
   localparam int MUL_DIGITS = 3;
   localparam int DIV_STEPS  = 32;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BANDWIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMESTEP  = 3'd5;

   localparam logic [31:0] GAIN_RESET  = 32'd65536;
   localparam logic [31:0] RATIO_RESET = 32'd65536;
   localparam logic [30:0] DT_RESET    = 31'd131;

   // program entry points
   localparam logic [STEP_W-1:0] STEP_LOAD = 6'd29;
   localparam logic [STEP_W-1:0] STEP_COMP = 6'd42;

   typedef struct packed {
      logic              req_type;
      logic signed [31:0] measured_position;
      logic signed [31:0] initial_velocity;
      logic signed [31:0] applied_torque;
   } eso_req_type;

   typedef struct packed {
      logic signed [47:0] position_estimate;
      logic signed [47:0] velocity_estimate;
      logic signed [47:0] disturbance_estimate;
      logic signed [31:0] torque_compensation;
      logic               gain_zero_flag;
   } eso_rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LDA,   // acc = a
      OP_ADA,   // acc += a
      OP_SBA,   // acc -= a
      OP_STA,   // dst = sat(acc)
      OP_MUL,   // dst = a * b, fixed point, saturated
      OP_DIV,   // compensation from last raw product
      OP_OUT    // deliver result, back to idle
   } op_type;

   typedef enum logic [4:0] {
      SRC_ZERO,
      SRC_POS,
      SRC_VEL,
      SRC_DIST,
      SRC_G1,
      SRC_G2,
      SRC_G3,
      SRC_T0,
      SRC_T1,
      SRC_T2,
      SRC_MEAS,
      SRC_IVEL,
      SRC_TORQ,
      SRC_BW,
      SRC_ALPHA,
      SRC_GAIN,
      SRC_DT,
      SRC_RATIO
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_POS,
      DST_VEL,
      DST_DIST,
      DST_G1,
      DST_G2,
      DST_G3,
      DST_T0,
      DST_T1,
      DST_T2
   } dst_type;

   typedef enum logic [1:0] {
      CD_NEXT,
      CD_LOAD,
      CD_ALWAYS
   } cond_type;

   typedef struct packed {
      op_type             op;
      src_type            src_a;
      src_type            src_b;
      dst_type            dst;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_MUL,
      PH_POST,
      PH_DIV,
      PH_FIN
   } phase_type;

   function automatic ucode_type uw(input op_type op, input src_type a, input src_type b,
                                    input dst_type d, input cond_type c,
                                    input logic [STEP_W-1:0] t);
      ucode_type w;
      w.op     = op;
      w.src_a  = a;
      w.src_b  = b;
      w.dst    = d;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   localparam logic [STEP_W-1:0] NO_TGT = 6'd0;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         // dispatch
         6'd0:  w = uw(OP_NOP, SRC_ZERO,  SRC_ZERO, DST_NONE, CD_LOAD, STEP_LOAD);
         // update: e = sat(meas - pos)
         6'd1:  w = uw(OP_LDA, SRC_MEAS,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd2:  w = uw(OP_SBA, SRC_POS,   SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd3:  w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_T0,   CD_NEXT, NO_TGT);
         // dp = sat(v + g1*e)
         6'd4:  w = uw(OP_MUL, SRC_G1,    SRC_T0,   DST_T1,   CD_NEXT, NO_TGT);
         6'd5:  w = uw(OP_LDA, SRC_VEL,   SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd6:  w = uw(OP_ADA, SRC_T1,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd7:  w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_T1,   CD_NEXT, NO_TGT);
         // dv = sat(d - alpha*v + b*torque + g2*e), one saturation at the end
         6'd8:  w = uw(OP_MUL, SRC_ALPHA, SRC_VEL,  DST_T2,   CD_NEXT, NO_TGT);
         6'd9:  w = uw(OP_LDA, SRC_DIST,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd10: w = uw(OP_SBA, SRC_T2,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd11: w = uw(OP_MUL, SRC_GAIN,  SRC_TORQ, DST_T2,   CD_NEXT, NO_TGT);
         6'd12: w = uw(OP_ADA, SRC_T2,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd13: w = uw(OP_MUL, SRC_G2,    SRC_T0,   DST_T2,   CD_NEXT, NO_TGT);
         6'd14: w = uw(OP_ADA, SRC_T2,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd15: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_T2,   CD_NEXT, NO_TGT);
         // dd = g3*e, overwrites e
         6'd16: w = uw(OP_MUL, SRC_G3,    SRC_T0,   DST_T0,   CD_NEXT, NO_TGT);
         // integrate
         6'd17: w = uw(OP_MUL, SRC_T1,    SRC_DT,   DST_T1,   CD_NEXT, NO_TGT);
         6'd18: w = uw(OP_LDA, SRC_POS,   SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd19: w = uw(OP_ADA, SRC_T1,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd20: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_POS,  CD_NEXT, NO_TGT);
         6'd21: w = uw(OP_MUL, SRC_T2,    SRC_DT,   DST_T2,   CD_NEXT, NO_TGT);
         6'd22: w = uw(OP_LDA, SRC_VEL,   SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd23: w = uw(OP_ADA, SRC_T2,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd24: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_VEL,  CD_NEXT, NO_TGT);
         6'd25: w = uw(OP_MUL, SRC_T0,    SRC_DT,   DST_T0,   CD_NEXT, NO_TGT);
         6'd26: w = uw(OP_LDA, SRC_DIST,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd27: w = uw(OP_ADA, SRC_T0,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd28: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_DIST, CD_ALWAYS, STEP_COMP);
         // load: seed estimates, clear disturbance, derive gains
         6'd29: w = uw(OP_LDA, SRC_MEAS,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd30: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_POS,  CD_NEXT, NO_TGT);
         6'd31: w = uw(OP_LDA, SRC_IVEL,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd32: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_VEL,  CD_NEXT, NO_TGT);
         6'd33: w = uw(OP_LDA, SRC_ZERO,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd34: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_DIST, CD_NEXT, NO_TGT);
         // g1 = 3w as a load and two adds
         6'd35: w = uw(OP_LDA, SRC_BW,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd36: w = uw(OP_ADA, SRC_BW,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd37: w = uw(OP_ADA, SRC_BW,    SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd38: w = uw(OP_STA, SRC_ZERO,  SRC_ZERO, DST_G1,   CD_NEXT, NO_TGT);
         6'd39: w = uw(OP_MUL, SRC_G1,    SRC_BW,   DST_G2,   CD_NEXT, NO_TGT);
         6'd40: w = uw(OP_MUL, SRC_BW,    SRC_BW,   DST_T0,   CD_NEXT, NO_TGT);
         6'd41: w = uw(OP_MUL, SRC_T0,    SRC_BW,   DST_G3,   CD_NEXT, NO_TGT);
         // compensation: raw ratio*d, then divide by b
         6'd42: w = uw(OP_MUL, SRC_RATIO, SRC_DIST, DST_NONE, CD_NEXT, NO_TGT);
         6'd43: w = uw(OP_DIV, SRC_ZERO,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         6'd44: w = uw(OP_OUT, SRC_ZERO,  SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
         default: w = uw(OP_OUT, SRC_ZERO, SRC_ZERO, DST_NONE, CD_NEXT, NO_TGT);
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/extended_state_observer_joint_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_state_observer_joint_core: third-order joint state observer
// Microcoded sequencer over a shared multiplier, accumulator and divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per observer call; req_type selects load (seed
//            estimates, derive gains) or update (one Euler step).
//   rsp_*  : one result item per request: the three estimates, the clamped
//            torque compensation and the zero-gain flag.
//   csr_*  : register writes, index 0..5 in the order bandwidth, damping,
//            control gain, ratio, limit, time step. Taken only while idle.
// Timing: one item at a time. Run time is set by the microprogram length: an
//   update runs longer than a load, and both are shorter when the control
//   gain is zero, as the divide is skipped. Each fixed point product runs on
//   the 48x16 multiplier as an entry step, three digit steps and a
//   saturating shift, and the compensation divide runs one quotient bit
//   per cycle.
// Stall: the result sits in an output register; a new item is accepted
//   while it waits. If the receiver stalls past the end of the next item's
//   program, the sequencer holds at its output step.
// Reset: synchronous; clears estimates and gains, loads register defaults.
// ----------------------------------------------------------------------------
module extended_state_observer_joint_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  eso_pkg::eso_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output eso_pkg::eso_rsp_type                rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [eso_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_data
);
   import eso_pkg::*;

   localparam logic [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
   localparam logic [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

   // configuration
   logic [31:0] bw_ff, bw_in;
   logic [31:0] alpha_ff, alpha_in;
   logic [31:0] gain_ff, gain_in;
   logic [31:0] ratio_ff, ratio_in;
   logic [30:0] limit_ff, limit_in;
   logic [30:0] dt_ff, dt_in;

   // observer state and scratch
   logic [EST_W-1:0] pos_ff, pos_in, vel_ff, vel_in, dist_ff, dist_in;
   logic [EST_W-1:0] g1_ff, g1_in, g2_ff, g2_in, g3_ff, g3_in;
   logic [EST_W-1:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   // sequencer
   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [5:0]        cnt_ff, cnt_in;
   eso_req_type       req_ff, req_in;
   ucode_type         uc;

   // multiplier
   logic [EST_W-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic              mneg_ff, mneg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [63:0]       pp;
   logic [PROD_W-1:0] shifted;
   logic [EST_W-1:0]  mlim, mmag, mres;

   // divider
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] gmag;
   logic [32:0] rem2;
   logic [30:0] cmag;
   logic [31:0] comp_ff, comp_in;
   logic        flag_ff, flag_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   eso_rsp_type rsp_ff, rsp_in;

   // operands and writeback
   logic [EST_W-1:0] opa, opb, wr_data;
   logic             wr_en, advance;
   logic [STEP_W-1:0] next_step;

   function automatic logic [EST_W-1:0] mag48(input logic [EST_W-1:0] x);
      return x[EST_W-1] ? (EST_W'(0) - x) : x;
   endfunction

   function automatic logic [EST_W-1:0] sat48(input logic [ACC_W-1:0] x);
      logic [ACC_W-EST_W:0] top;
      top = x[ACC_W-1:EST_W-1];
      if (top == '0 || top == '1) begin
         return x[EST_W-1:0];
      end
      return x[ACC_W-1] ? EST_MIN : EST_MAX;
   endfunction

   function automatic logic [EST_W-1:0] sext32(input logic [31:0] x);
      return {{(EST_W-32){x[31]}}, x};
   endfunction

   assign uc = ucode_rom(step_ff);

   // operand selection
   always_comb begin
      case (uc.src_a)
         SRC_ZERO:  opa = '0;
         SRC_POS:   opa = pos_ff;
         SRC_VEL:   opa = vel_ff;
         SRC_DIST:  opa = dist_ff;
         SRC_G1:    opa = g1_ff;
         SRC_G2:    opa = g2_ff;
         SRC_G3:    opa = g3_ff;
         SRC_T0:    opa = t0_ff;
         SRC_T1:    opa = t1_ff;
         SRC_T2:    opa = t2_ff;
         SRC_MEAS:  opa = sext32(req_ff.measured_position);
         SRC_IVEL:  opa = sext32(req_ff.initial_velocity);
         SRC_TORQ:  opa = sext32(req_ff.applied_torque);
         SRC_BW:    opa = {{(EST_W-32){1'b0}}, bw_ff};
         SRC_ALPHA: opa = sext32(alpha_ff);
         SRC_GAIN:  opa = sext32(gain_ff);
         SRC_DT:    opa = {{(EST_W-31){1'b0}}, dt_ff};
         SRC_RATIO: opa = sext32(ratio_ff);
         default:   opa = '0;
      endcase
      case (uc.src_b)
         SRC_ZERO:  opb = '0;
         SRC_POS:   opb = pos_ff;
         SRC_VEL:   opb = vel_ff;
         SRC_DIST:  opb = dist_ff;
         SRC_G1:    opb = g1_ff;
         SRC_G2:    opb = g2_ff;
         SRC_G3:    opb = g3_ff;
         SRC_T0:    opb = t0_ff;
         SRC_T1:    opb = t1_ff;
         SRC_T2:    opb = t2_ff;
         SRC_MEAS:  opb = sext32(req_ff.measured_position);
         SRC_IVEL:  opb = sext32(req_ff.initial_velocity);
         SRC_TORQ:  opb = sext32(req_ff.applied_torque);
         SRC_BW:    opb = {{(EST_W-32){1'b0}}, bw_ff};
         SRC_ALPHA: opb = sext32(alpha_ff);
         SRC_GAIN:  opb = sext32(gain_ff);
         SRC_DT:    opb = {{(EST_W-31){1'b0}}, dt_ff};
         SRC_RATIO: opb = sext32(ratio_ff);
         default:   opb = '0;
      endcase
   end

   // datapath helpers
   always_comb begin
      pp      = ma_ff * mb_ff[DIGIT_W-1:0];
      shifted = prod_ff >> FRAC_BITS;
      mlim    = mneg_ff ? EST_MIN : EST_MAX;
      if ((|shifted[PROD_W-1:EST_W]) || (shifted[EST_W-1:0] > mlim)) begin
         mmag = mlim;
      end else begin
         mmag = shifted[EST_W-1:0];
      end
      mres = mneg_ff ? (EST_W'(0) - mmag) : mmag;

      gmag = gain_ff[31] ? (32'd0 - gain_ff) : gain_ff;
      rem2 = {rem_ff, quo_ff[31]};
      if (ovf_ff || (quo_ff > {1'b0, limit_ff})) begin
         cmag = limit_ff;
      end else begin
         cmag = quo_ff[30:0];
      end

      if (uc.cond == CD_ALWAYS || (uc.cond == CD_LOAD && req_ff.req_type == REQ_LOAD)) begin
         next_step = uc.target;
      end else begin
         next_step = step_ff + 6'd1;
      end
   end

   // next state and outputs
   always_comb begin
      bw_in        = bw_ff;
      alpha_in     = alpha_ff;
      gain_in      = gain_ff;
      ratio_in     = ratio_ff;
      limit_in     = limit_ff;
      dt_in        = dt_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      dist_in      = dist_ff;
      g1_in        = g1_ff;
      g2_in        = g2_ff;
      g3_in        = g3_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      acc_in       = acc_ff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      comp_in      = comp_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = '0;
      advance      = 1'b0;

      req_stall = (state_ff != ST_IDLE);
      csr_ready = (state_ff == ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BANDWIDTH: bw_in    = csr_data;
            CSR_DAMPING:   alpha_in = csr_data;
            CSR_GAIN:      gain_in  = csr_data;
            CSR_RATIO:     ratio_in = csr_data;
            CSR_LIMIT:     limit_in = csr_data[30:0];
            CSR_TIMESTEP:  dt_in    = csr_data[30:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_RUN;
               step_in  = '0;
               phase_in = PH_START;
            end
         end
         ST_RUN: begin
            case (uc.op)
               OP_NOP: advance = 1'b1;
               OP_LDA: begin
                  acc_in  = {{(ACC_W-EST_W){opa[EST_W-1]}}, opa};
                  advance = 1'b1;
               end
               OP_ADA: begin
                  acc_in  = acc_ff + {{(ACC_W-EST_W){opa[EST_W-1]}}, opa};
                  advance = 1'b1;
               end
               OP_SBA: begin
                  acc_in  = acc_ff - {{(ACC_W-EST_W){opa[EST_W-1]}}, opa};
                  advance = 1'b1;
               end
               OP_STA: begin
                  wr_en   = 1'b1;
                  wr_data = sat48(acc_ff);
                  advance = 1'b1;
               end
               OP_MUL: begin
                  case (phase_ff)
                     PH_START: begin
                        ma_in    = mag48(opa);
                        mb_in    = mag48(opb);
                        mneg_in  = opa[EST_W-1] ^ opb[EST_W-1];
                        prod_in  = '0;
                        cnt_in   = '0;
                        phase_in = PH_MUL;
                     end
                     PH_MUL: begin
                        // low digit first; partial lands high, sum shifts down
                        prod_in = (prod_ff >> DIGIT_W) + {pp, {(PROD_W-64){1'b0}}};
                        mb_in   = mb_ff >> DIGIT_W;
                        cnt_in  = cnt_ff + 6'd1;
                        if (cnt_ff == 6'(MUL_DIGITS - 1)) begin
                           phase_in = PH_POST;
                        end
                     end
                     PH_POST: begin
                        wr_en    = 1'b1;
                        wr_data  = mres;
                        phase_in = PH_START;
                        advance  = 1'b1;
                     end
                     default: phase_in = PH_START;
                  endcase
               end
               OP_DIV: begin
                  case (phase_ff)
                     PH_START: begin
                        flag_in = (gain_ff == 32'd0);
                        if (gain_ff == 32'd0) begin
                           comp_in = '0;
                           advance = 1'b1;
                        end else begin
                           // quotient would not fit 32 bits: clamp anyway
                           ovf_in   = (prod_ff[PROD_W-1:32] >= {32'd0, gmag});
                           rem_in   = prod_ff[63:32];
                           quo_in   = prod_ff[31:0];
                           cnt_in   = '0;
                           phase_in = PH_DIV;
                        end
                     end
                     PH_DIV: begin
                        if (rem2 >= {1'b0, gmag}) begin
                           rem_in = 32'(rem2 - {1'b0, gmag});
                           quo_in = {quo_ff[30:0], 1'b1};
                        end else begin
                           rem_in = rem2[31:0];
                           quo_in = {quo_ff[30:0], 1'b0};
                        end
                        cnt_in = cnt_ff + 6'd1;
                        if (cnt_ff == 6'(DIV_STEPS - 1)) begin
                           phase_in = PH_FIN;
                        end
                     end
                     PH_FIN: begin
                        // result is -(ratio*d)/b
                        if (mneg_ff ^ gain_ff[31]) begin
                           comp_in = {1'b0, cmag};
                        end else begin
                           comp_in = 32'd0 - {1'b0, cmag};
                        end
                        phase_in = PH_START;
                        advance  = 1'b1;
                     end
                     default: phase_in = PH_START;
                  endcase
               end
               OP_OUT: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     rsp_in.position_estimate    = pos_ff;
                     rsp_in.velocity_estimate    = vel_ff;
                     rsp_in.disturbance_estimate = dist_ff;
                     rsp_in.torque_compensation  = comp_ff;
                     rsp_in.gain_zero_flag       = flag_ff;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                     step_in      = '0;
                  end
               end
               default: advance = 1'b1;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase

      if (advance) begin
         step_in = next_step;
      end

      if (wr_en) begin
         case (uc.dst)
            DST_POS:  pos_in  = wr_data;
            DST_VEL:  vel_in  = wr_data;
            DST_DIST: dist_in = wr_data;
            DST_G1:   g1_in   = wr_data;
            DST_G2:   g2_in   = wr_data;
            DST_G3:   g3_in   = wr_data;
            DST_T0:   t0_in   = wr_data;
            DST_T1:   t1_in   = wr_data;
            DST_T2:   t2_in   = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_START;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bw_ff        <= '0;
         alpha_ff     <= '0;
         gain_ff      <= GAIN_RESET;
         ratio_ff     <= RATIO_RESET;
         limit_ff     <= '0;
         dt_ff        <= DT_RESET;
         pos_ff       <= '0;
         vel_ff       <= '0;
         dist_ff      <= '0;
         g1_ff        <= '0;
         g2_ff        <= '0;
         g3_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         bw_ff        <= bw_in;
         alpha_ff     <= alpha_in;
         gain_ff      <= gain_in;
         ratio_ff     <= ratio_in;
         limit_ff     <= limit_in;
         dt_ff        <= dt_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         dist_ff      <= dist_in;
         g1_ff        <= g1_in;
         g2_ff        <= g2_in;
         g3_ff        <= g3_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      req_ff  <= req_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      mneg_ff <= mneg_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
      comp_ff <= comp_in;
      flag_ff <= flag_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // an accepted item keeps the input side busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after item accept");

   // datapath sub-phase only runs inside a program
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (phase_ff == PH_START))
      else $error("datapath phase active while idle");

   // zero control gain forces zero compensation
   a_zero_gain_comp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.gain_zero_flag) |-> (rsp_payload.torque_compensation == 32'sd0))
      else $error("compensation nonzero with zero control gain");

   // config writes only land while no program runs
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> (state_ff == ST_IDLE && step_ff == '0))
      else $error("register write during a program");

endmodule
